// ===== rtl/core/odl_pkg.sv =====
// ============================================================================
// odl_pkg
// Shared widths, request codes and status codes of the ordered deque list.
// ============================================================================
package odl_pkg;

    localparam int OP_W          = 3;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam int REMOVED_LSB = 0;
    localparam int FOUND_BIT   = VALUE_W;
    localparam int STATUS_LSB  = VALUE_W + 1;
    localparam int COUNT_LSB   = VALUE_W + 1 + STATUS_W;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd5;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd6;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd3;

endpackage

// ===== rtl/core/odl_ram.sv =====
// ============================================================================
// odl_ram
// Generic simple dual-port ram, one write port and one registered read port.
// ============================================================================
module odl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/ordered_deque_list_top.sv =====
// ============================================================================
// ordered_deque_list_top
// Bounded list of signed 32-bit values with deque, ordered insert, delete and
// search requests, worked by one compare unit over a ram of entries.
// ============================================================================
// usage
//   s_axis carries one request: operation and item_value. s_axis_tready is high
//   only while the sequencer is idle, so one request is worked at a time.
//   m_axis carries exactly one result per request: removed_value, found,
//   status and entry_count. The result sits in an output register, so the
//   next request is taken while a result still waits to be taken.
//   Push front and pop front shift every entry held, search and delete scan
//   the entries, delete then shifts the tail, and ordered insert checks the
//   front and back entries before it scans and shifts. A scan or a shift
//   moves one entry a cycle through the single ram read port; a scan tests
//   each entry in the shared compare unit.
//   A stalled m_axis holds the result and the sequencer waits in its last
//   step until the output register frees up.
//   Reset empties the list at once; entries are never read above the count,
//   so the ram needs no clearing pass.
// ============================================================================
module ordered_deque_list_top #(
    parameter int CAPACITY = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // operation[2:0], item_value[34:3], zero fill
    input  logic [odl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // removed_value[31:0], found[32], status[34:33], entry_count[39:35]
    output logic [odl_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    import odl_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FRONT,
        S_CHK_FRONT,
        S_CHK_BACK,
        S_SCAN,
        S_SHR,
        S_SHL,
        S_PUT,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        last_reg, last_next;
    logic                 iss_reg, iss_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [CW-1:0]        rd_addr_reg, rd_addr_next;
    logic [VALUE_W-1:0]   removed_reg, removed_next;
    logic                 found_reg, found_next;
    logic [STATUS_W-1:0]  stat_reg, stat_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [OP_W-1:0]      in_op;
    logic [VALUE_W-1:0]   in_val;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [VALUE_W-1:0]   ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [VALUE_W-1:0]   ram_rdata;
    logic                 cmp_ge;
    logic                 cmp_eq;
    logic                 hit;
    logic [CW-1:0]        cnt_last;
    logic                 is_full;

    assign in_op  = s_axis_tdata[OP_W-1:0];
    assign in_val = s_axis_tdata[OP_W +: VALUE_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // shared compare unit
    assign cmp_ge = $signed(ram_rdata) >= $signed(val_reg);
    assign cmp_eq = ram_rdata == val_reg;
    assign hit    = (op_reg == OP_INSERT) ? cmp_ge : cmp_eq;

    assign cnt_last = cnt_reg - CW'(1);
    assign is_full  = cnt_reg == CW'(CAPACITY);

    odl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        iss_next      = iss_reg;
        rd_vld_next   = 1'b0;
        rd_addr_next  = rd_addr_reg;
        removed_next  = removed_reg;
        found_next    = found_reg;
        stat_next     = stat_reg;
        m_tvalid_next = m_tvalid_reg && !m_axis_tready;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg[AW-1:0];
        ram_wdata     = val_reg;
        ram_raddr     = '0;

        // sweep address issue for scan and shifts
        if ((state_reg == S_SCAN || state_reg == S_SHR || state_reg == S_SHL) && iss_reg)
        begin
            ram_raddr    = idx_reg[AW-1:0];
            rd_vld_next  = 1'b1;
            rd_addr_next = idx_reg;
            if (idx_reg == last_reg)
            begin
                iss_next = 1'b0;
            end
            else if (state_reg == S_SHR)
            begin
                idx_next = idx_reg - CW'(1);
            end
            else
            begin
                idx_next = idx_reg + CW'(1);
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next      = in_op;
                    val_next     = in_val;
                    removed_next = '0;
                    found_next   = 1'b0;
                    stat_next    = STAT_OK;
                    state_next   = S_DONE;
                    case (in_op) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT:
                        begin
                            if (is_full)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else if (in_op == OP_PUSH_BACK)
                            begin
                                pos_next   = cnt_reg;
                                state_next = S_PUT;
                            end
                            else if (cnt_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_PUT;
                            end
                            else if (in_op == OP_PUSH_FRONT)
                            begin
                                pos_next   = '0;
                                idx_next   = cnt_last;
                                last_next  = '0;
                                iss_next   = 1'b1;
                                state_next = S_SHR;
                            end
                            else
                            begin
                                state_next = S_RD_FRONT;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                pos_next   = (in_op == OP_POP_FRONT) ? '0 : cnt_last;
                                idx_next   = (in_op == OP_POP_FRONT) ? '0 : cnt_last;
                                last_next  = cnt_last;
                                iss_next   = 1'b1;
                                state_next = S_SHL;
                            end
                        end
                        OP_DELETE, OP_SEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next = (in_op == OP_DELETE) ? STAT_ABSENT : STAT_OK;
                            end
                            else
                            begin
                                idx_next   = '0;
                                last_next  = cnt_last;
                                iss_next   = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RD_FRONT:
            begin
                ram_raddr  = '0;
                state_next = S_CHK_FRONT;
            end
            S_CHK_FRONT:
            begin
                if (cmp_ge)
                begin
                    pos_next   = '0;
                    idx_next   = cnt_last;
                    last_next  = '0;
                    iss_next   = 1'b1;
                    state_next = S_SHR;
                end
                else
                begin
                    ram_raddr  = cnt_last[AW-1:0];
                    state_next = S_CHK_BACK;
                end
            end
            S_CHK_BACK:
            begin
                if (!cmp_ge || cmp_eq)
                begin
                    pos_next   = cnt_reg;
                    state_next = S_PUT;
                end
                else
                begin
                    idx_next   = '0;
                    last_next  = cnt_last;
                    iss_next   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_vld_reg)
                begin
                    if (hit)
                    begin
                        pos_next    = rd_addr_reg;
                        rd_vld_next = 1'b0;
                        iss_next    = 1'b1;
                        if (op_reg == OP_INSERT)
                        begin
                            idx_next   = cnt_last;
                            last_next  = rd_addr_reg;
                            state_next = S_SHR;
                        end
                        else if (op_reg == OP_DELETE)
                        begin
                            found_next = 1'b1;
                            idx_next   = rd_addr_reg;
                            last_next  = cnt_last;
                            state_next = S_SHL;
                        end
                        else
                        begin
                            found_next = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    else if (rd_addr_reg == last_reg)
                    begin
                        stat_next  = (op_reg == OP_DELETE) ? STAT_ABSENT : STAT_OK;
                        state_next = S_DONE;
                    end
                end
            end
            S_SHR:
            begin
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(rd_addr_reg + CW'(1));
                    ram_wdata = ram_rdata;
                    if (rd_addr_reg == last_reg)
                    begin
                        state_next = S_PUT;
                    end
                end
            end
            S_SHL:
            begin
                if (rd_vld_reg)
                begin
                    if (rd_addr_reg != pos_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(rd_addr_reg - CW'(1));
                        ram_wdata = ram_rdata;
                    end
                    else if (op_reg == OP_POP_FRONT || op_reg == OP_POP_BACK)
                    begin
                        removed_next = ram_rdata;
                    end
                    if (rd_addr_reg == last_reg)
                    begin
                        cnt_next   = cnt_last;
                        state_next = S_DONE;
                    end
                end
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = val_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {COUNT_FIELD_W'(cnt_reg), stat_reg, found_reg,
                                     removed_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            iss_reg      <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            iss_reg      <= iss_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        rd_addr_reg <= rd_addr_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
        stat_reg    <= stat_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== rtl/core/odl_checker.sv =====
// ============================================================================
// odl_checker
// Port-level checks of the ordered deque list, bound to the top level.
// ============================================================================
module odl_checker #(
    parameter int CAPACITY = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [odl_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [odl_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import odl_pkg::*;

    logic [VALUE_W-1:0]       removed;
    logic                     found;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_FIELD_W-1:0] entry_count;

    assign removed     = m_axis_tdata[REMOVED_LSB +: VALUE_W];
    assign found       = m_axis_tdata[FOUND_BIT];
    assign status      = m_axis_tdata[STATUS_LSB +: STATUS_W];
    assign entry_count = m_axis_tdata[COUNT_LSB +: COUNT_FIELD_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is worked");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status == STAT_EMPTY |-> entry_count == '0 && removed == '0
            && !found)
        else $error("empty pop result inconsistent");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status == STAT_FULL |-> entry_count == COUNT_FIELD_W'(CAPACITY))
        else $error("full status with list not full");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && found |-> status == STAT_OK && removed == '0)
        else $error("match reported with bad status");

endmodule

bind ordered_deque_list_top odl_checker #(.CAPACITY(CAPACITY)) u_odl_checker (.*);

// ===== verif/ordered_deque_list_top_tb.sv =====
// ============================================================================
// ordered_deque_list_top_tb
// Self-checking bench for the ordered deque list. A shadow list in the bench
// tracks every accepted request and queues the result it must produce. The
// monitor compares each returned result field by field, in order. Stimulus
// starts with a short directed pass over empty, full, extreme and ordering
// cases. Random phases follow that fill, drain or mix the list. Both stream
// sides pause at random, apart from calm stretches.
// ============================================================================
module ordered_deque_list_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import odl_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 1800;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        int unsigned               gap;
        bit                        drain;
    } list_req_t;

    typedef struct {
        logic signed [VALUE_W-1:0] removed;
        logic                      found;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_FIELD_W-1:0]  count;
    } list_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    list_req_t request_queue [$];
    list_rsp_t due_results [$];
    logic signed [VALUE_W-1:0] value_pool [$];

    logic signed [VALUE_W-1:0] shadow_vals [LIST_DEPTH];
    int shadow_len = 0;

    list_req_t next_req;
    list_req_t on_bus;
    bit staged = 1'b0;
    int unsigned hold_cycles = 0;

    int unsigned rx_hold = 0;
    bit rx_calm = 1'b0;

    int errors = 0;
    int accepted = 0;
    int checked = 0;
    int n_empty = 0;
    int n_full = 0;
    int n_absent = 0;
    int n_hits = 0;
    int peak_len = 0;
    int phases = 0;

    ordered_deque_list_top #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    task automatic apply_to_shadow_list(input list_req_t r);
        list_rsp_t rsp;
        int pos;
        int i;
        rsp.removed = '0;
        rsp.found = 1'b0;
        rsp.status = STAT_OK;
        pos = -1;
        case (r.op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT:
            begin
                if (shadow_len >= LIST_DEPTH)
                begin
                    rsp.status = STAT_FULL;
                end
                else
                begin
                    if (r.op == OP_PUSH_FRONT)
                        pos = 0;
                    else if (r.op == OP_PUSH_BACK)
                        pos = shadow_len;
                    else if (shadow_len == 0 || r.value <= shadow_vals[0])
                        pos = 0;
                    else if (r.value >= shadow_vals[shadow_len-1])
                        pos = shadow_len;
                    else
                    begin
                        pos = shadow_len;
                        for (i = shadow_len - 1; i >= 0; i--)
                            if (shadow_vals[i] >= r.value)
                                pos = i;
                    end
                    for (i = shadow_len; i > pos; i--)
                        shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[pos] = r.value;
                    shadow_len++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (shadow_len == 0)
                begin
                    rsp.status = STAT_EMPTY;
                end
                else if (r.op == OP_POP_FRONT)
                begin
                    rsp.removed = shadow_vals[0];
                    for (i = 0; i + 1 < shadow_len; i++)
                        shadow_vals[i] = shadow_vals[i+1];
                    shadow_len--;
                end
                else
                begin
                    rsp.removed = shadow_vals[shadow_len-1];
                    shadow_len--;
                end
            end
            OP_DELETE, OP_SEARCH:
            begin
                for (i = shadow_len - 1; i >= 0; i--)
                    if (shadow_vals[i] == r.value)
                        pos = i;
                rsp.found = (pos >= 0);
                if (r.op == OP_DELETE)
                begin
                    if (pos < 0)
                    begin
                        rsp.status = STAT_ABSENT;
                    end
                    else
                    begin
                        for (i = pos; i + 1 < shadow_len; i++)
                            shadow_vals[i] = shadow_vals[i+1];
                        shadow_len--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        rsp.count = COUNT_FIELD_W'(shadow_len);
        if (rsp.status == STAT_EMPTY) n_empty++;
        if (rsp.status == STAT_FULL) n_full++;
        if (rsp.status == STAT_ABSENT) n_absent++;
        if (rsp.found) n_hits++;
        if (shadow_len > peak_len) peak_len = shadow_len;
        due_results.push_back(rsp);
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            staged = 1'b0;
            hold_cycles = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_to_shadow_list(on_bus);
                accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (!staged && request_queue.size() > 0)
                begin
                    next_req = request_queue.pop_front();
                    hold_cycles = next_req.gap;
                    staged = 1'b1;
                end
                if (staged && hold_cycles == 0 &&
                    !(next_req.drain && due_results.size() != 0))
                begin
                    s_axis_tdata <= {{(S_TDATA_W-OP_W-VALUE_W){1'b0}},
                                     next_req.value, next_req.op};
                    s_axis_tvalid <= 1'b1;
                    on_bus = next_req;
                    staged = 1'b0;
                end
                else
                begin
                    if (hold_cycles > 0)
                        hold_cycles--;
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        list_rsp_t want;
        list_rsp_t got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_hold = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.removed = m_axis_tdata[REMOVED_LSB +: VALUE_W];
                got.found = m_axis_tdata[FOUND_BIT];
                got.status = m_axis_tdata[STATUS_LSB +: STATUS_W];
                got.count = m_axis_tdata[COUNT_LSB +: COUNT_FIELD_W];
                if (due_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, data %h", m_axis_tdata));
                end
                else
                begin
                    want = due_results.pop_front();
                    checked++;
                    if (got.removed !== want.removed)
                        report_mismatch($sformatf("result %0d removed_value exp %0d got %0d",
                                                  checked, want.removed, got.removed));
                    if (got.found !== want.found)
                        report_mismatch($sformatf("result %0d found exp %0d got %0d",
                                                  checked, want.found, got.found));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("result %0d status exp %0d got %0d",
                                                  checked, want.status, got.status));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("result %0d entry_count exp %0d got %0d",
                                                  checked, want.count, got.count));
                end
                rx_hold = rx_calm ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 63) == 0)
                    rx_calm = !rx_calm;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic queue_request(input logic [OP_W-1:0] op,
                                 input logic signed [VALUE_W-1:0] value,
                                 input int unsigned gap, input bit drain);
        list_req_t r;
        r.op = op;
        r.value = value;
        r.gap = gap;
        r.drain = drain;
        request_queue.push_back(r);
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK || op == OP_INSERT)
        begin
            value_pool.push_back(value);
            if (value_pool.size() > 24)
                void'(value_pool.pop_front());
        end
    endtask

    // request mix per phase: 0 fill, 1 drain, 2 mixed
    function automatic logic [OP_W-1:0] pick_op(input int kind);
        logic [OP_W-1:0] codes [8];
        int bounds [7];
        int r;
        int k;
        codes = '{OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT, OP_POP_FRONT,
                  OP_POP_BACK, OP_DELETE, OP_SEARCH, OP_UNUSED};
        case (kind)
            0: bounds = '{25, 50, 75, 83, 90, 95, 99};
            1: bounds = '{8, 16, 26, 48, 70, 88, 98};
            default: bounds = '{14, 28, 46, 58, 70, 84, 97};
        endcase
        r = $urandom_range(0, 99);
        for (k = 0; k < 7; k++)
            if (r < bounds[k])
                return codes[k];
        return codes[7];
    endfunction

    function automatic logic signed [VALUE_W-1:0] draw_value();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 3 && value_pool.size() > 0)
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        if (r <= 4)
            return $signed($urandom_range(0, 40)) - 20;
        if (r == 5)
        begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    initial
    begin : stimulus
        int real_items;
        int kind;
        int span;
        int k;
        bit calm_tx;
        logic [OP_W-1:0] op;

        // empty list corners
        queue_request(OP_POP_FRONT, 32'sd9, $urandom_range(0, 16), 1'b0);
        queue_request(OP_POP_BACK, -32'sd9, $urandom_range(0, 16), 1'b0);
        queue_request(OP_DELETE, 32'sd5, $urandom_range(0, 16), 1'b0);
        queue_request(OP_SEARCH, 32'sd5, $urandom_range(0, 16), 1'b0);
        queue_request(OP_UNUSED, -32'sd1, $urandom_range(0, 16), 1'b0);
        // fill to capacity, extremes, duplicates and broken order
        queue_request(OP_INSERT, 32'sd0, 0, 1'b0);
        queue_request(OP_PUSH_FRONT, VAL_MIN, 0, 1'b0);
        queue_request(OP_PUSH_BACK, VAL_MAX, 0, 1'b0);
        queue_request(OP_INSERT, VAL_MIN, 0, 1'b0);
        queue_request(OP_INSERT, VAL_MAX, 0, 1'b0);
        queue_request(OP_INSERT, -32'sd1, $urandom_range(0, 16), 1'b0);
        queue_request(OP_INSERT, 32'sd1, 0, 1'b0);
        queue_request(OP_PUSH_FRONT, 32'sd5, 0, 1'b0);
        queue_request(OP_INSERT, 32'sd3, 0, 1'b0);
        queue_request(OP_INSERT, 32'sd0, $urandom_range(0, 16), 1'b0);
        queue_request(OP_PUSH_BACK, 32'sd7, 0, 1'b0);
        queue_request(OP_INSERT, 32'sd2, 0, 1'b0);
        queue_request(OP_PUSH_FRONT, -32'sd7, 0, 1'b0);
        queue_request(OP_INSERT, 32'sd100, 0, 1'b0);
        queue_request(OP_PUSH_BACK, -32'sd100, 0, 1'b0);
        queue_request(OP_INSERT, 32'sd50, $urandom_range(0, 16), 1'b0);
        // full list rejects every kind of push, then search, delete and both pops run
        queue_request(OP_PUSH_FRONT, 32'sd11, 0, 1'b0);
        queue_request(OP_PUSH_BACK, 32'sd12, 0, 1'b0);
        queue_request(OP_INSERT, 32'sd13, 0, 1'b0);
        queue_request(OP_SEARCH, VAL_MAX, 0, 1'b0);
        queue_request(OP_DELETE, 32'sd0, 0, 1'b0);
        queue_request(OP_POP_FRONT, 32'sd0, 0, 1'b0);
        queue_request(OP_POP_BACK, 32'sd0, 0, 1'b0);
        queue_request(OP_INSERT, 32'sd4, 0, 1'b1);

        real_items = 0;
        while (real_items < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 2);
            span = $urandom_range(20, 80);
            calm_tx = ($urandom_range(0, 3) == 0);
            for (k = 0; k < span; k++)
            begin
                op = pick_op(kind);
                queue_request(op, draw_value(), calm_tx ? 0 : $urandom_range(0, 16),
                              k == 0 && (phases == 2 || $urandom_range(0, 3) == 0));
                if (op != OP_UNUSED)
                    real_items++;
            end
            phases++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || staged || s_axis_tvalid || due_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));

        $display("covered %0d requests over %0d random phases, peak fill %0d of %0d",
                 accepted, phases, peak_len, LIST_DEPTH);
        $display("empty pops %0d, rejected pushes %0d, absent deletes %0d, matches %0d",
                 n_empty, n_full, n_absent, n_hits);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
